// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the checker files
// expects signals named clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CPS_ASSERT_IMPL(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define CPS_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== hw/rtl/cps_pkg.sv =====
// shared widths, constants and types of the charlier polynomial sequence block
// no dependencies
`default_nettype none

package cps_pkg;

  localparam int MAX_DEGREE = 31;

  localparam int X_W     = 32;
  localparam int MEAN_W  = 32;
  localparam int DEG_W   = 5;
  localparam int VAL_W   = 64;
  localparam int FRAC_W  = 16;
  localparam int MMX_W   = 34;
  localparam int FACT_W  = 34;
  localparam int FMAG_W  = FACT_W - 1;
  localparam int HALF_W  = VAL_W / 2;
  localparam int PROD_W  = FMAG_W + HALF_W;
  localparam int T1_W    = PROD_W + HALF_W;
  localparam int T2_W    = VAL_W + DEG_W;
  localparam int NUM_W   = 98;
  localparam int DIV_CNT_W = $clog2(VAL_W);

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;
  localparam int IN_PAD_W    = IN_TDATA_W - X_W - DEG_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - DEG_W;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int REG_LSB = 2;
  localparam logic [APB_AW-REG_LSB-1:0] REG_POISSON_MEAN = '0;
  localparam logic [MEAN_W-1:0] MEAN_RESET = 32'h0001_0000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [VAL_W-1:0] ONE_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // one command from the front: a - x and the clamped top degree
  typedef struct packed {
    logic [MMX_W-1:0] mmx;
    logic [DEG_W-1:0] top;
  } cmd_t;

  // divider status and result
  typedef struct packed {
    logic             done;
    logic             sat;
    logic [VAL_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cps_front.sv =====
// front end: accepts input items, forms a - x and clamps the top degree
// depends on cps_pkg
`default_nettype none

module cps_front import cps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [X_W-1:0]    x_value,
  input  logic [DEG_W-1:0]  top_degree,
  input  logic [MEAN_W-1:0] mean,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  logic             hold_valid;
  cmd_t             hold;
  logic [MMX_W-1:0] mmx_next;
  logic [DEG_W-1:0] top_next;

  assign mmx_next = {2'b00, mean} - {{(MMX_W-X_W){x_value[X_W-1]}}, x_value};
  assign top_next = (top_degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : top_degree;

  assign in_ready  = !hold_valid || cmd_ready;
  assign cmd_valid = hold_valid;
  assign cmd       = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold.mmx <= mmx_next;
      hold.top <= top_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cps_queue.sv =====
// short command queue between the front end and the recurrence engine
// depends on cps_pkg
`default_nettype none

module cps_queue import cps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cps_div.sv =====
// iterative signed divider by the mean, one quotient bit a cycle, saturating
// depends on cps_pkg
`default_nettype none

module cps_div import cps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [MEAN_W-1:0] den,
  output div_rsp_t          rsp
);

  typedef enum logic [2:0] {
    D_IDLE,
    D_ABS,
    D_CHECK,
    D_RUN,
    D_FIX
  } div_state_t;

  div_state_t           state;
  logic                 neg;
  logic [NUM_W-1:0]     mag;
  logic [MEAN_W-1:0]    rem;
  logic [VAL_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic [MEAN_W:0]      trial;
  logic [MEAN_W:0]      diff;
  logic                 fits;

  assign trial = {rem, quo[VAL_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      case (state)
        D_IDLE: begin
          rsp.done <= 1'b0;
          if (start) begin
            neg   <= num[NUM_W-1];
            mag   <= num;
            state <= D_ABS;
          end
        end
        D_ABS: begin
          rsp.done <= 1'b0;
          if (neg) begin
            mag <= -mag;
          end
          state <= D_CHECK;
        end
        D_CHECK: begin
          if (mag == '0) begin
            rsp.quot <= '0;
            rsp.sat  <= 1'b0;
            rsp.done <= 1'b1;
            state    <= D_IDLE;
          end else if (mag[NUM_W-1:VAL_W] >= (NUM_W-VAL_W)'(den)) begin
            // quotient of 2^64 or more, also any nonzero over a zero mean
            rsp.quot <= neg ? VAL_MIN : VAL_MAX;
            rsp.sat  <= 1'b1;
            rsp.done <= 1'b1;
            state    <= D_IDLE;
          end else begin
            rsp.done <= 1'b0;
            rem      <= mag[VAL_W+MEAN_W-1:VAL_W];
            quo      <= mag[VAL_W-1:0];
            cnt      <= '0;
            state    <= D_RUN;
          end
        end
        D_RUN: begin
          rsp.done <= 1'b0;
          if (fits) begin
            rem <= diff[MEAN_W-1:0];
            quo <= {quo[VAL_W-2:0], 1'b1};
          end else begin
            rem <= trial[MEAN_W-1:0];
            quo <= {quo[VAL_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(VAL_W - 1)) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          // negative side reaches one step further than the positive side
          if (neg) begin
            rsp.sat  <= (quo > VAL_MIN);
            rsp.quot <= (quo > VAL_MIN) ? VAL_MIN : -quo;
          end else begin
            rsp.sat  <= quo[VAL_W-1];
            rsp.quot <= quo[VAL_W-1] ? VAL_MAX : quo;
          end
          rsp.done <= 1'b1;
          state    <= D_IDLE;
        end
        default: begin
          rsp.done <= 1'b0;
          state    <= D_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cps_back.sv =====
// recurrence engine: runs the three-term recurrence for one command and
// holds each result in an output register; depends on cps_pkg and cps_div
`default_nettype none

module cps_back import cps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [MEAN_W-1:0] mean,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DEG_W-1:0]  out_degree,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_sat,
  output logic              out_last
);

  typedef enum logic [3:0] {
    B_IDLE,
    B_FACT,
    B_MUL_LO,
    B_MUL_HI,
    B_SUM,
    B_SIGN,
    B_COMB,
    B_DSTART,
    B_DIV,
    B_EMIT
  } back_state_t;

  back_state_t       state;
  logic [MMX_W-1:0]  mmx;
  logic [VAL_W-1:0]  vp;
  logic [VAL_W-1:0]  vp2;
  logic [DEG_W-1:0]  k;
  logic [DEG_W-1:0]  top;
  logic              ovf;

  logic [FMAG_W-1:0] fmag;
  logic              t1neg;
  logic [VAL_W-1:0]  vmag;
  logic [VAL_W-1:0]  vp2mag;
  logic              t2neg;
  logic [PROD_W-1:0] acc_lo;
  logic [PROD_W-1:0] acc_hi;
  logic [T2_W-1:0]   t2mag;
  logic [T1_W-1:0]   t1mag;
  logic [NUM_W-1:0]  s1;
  logic [NUM_W-1:0]  s2;
  logic [NUM_W-1:0]  num;

  logic [FACT_W-1:0] factor;
  logic [FACT_W-1:0] fabs;
  logic [NUM_W-1:0]  t1ext;
  logic [NUM_W-1:0]  t2ext;
  logic [DEG_W-1:0]  k_inc;
  logic              out_free;
  logic              out_load;
  logic              div_start;
  div_rsp_t          div_rsp;

  assign factor = mmx + {{(FACT_W-DEG_W-FRAC_W){1'b0}}, k, {FRAC_W{1'b0}}};
  assign fabs   = factor[FACT_W-1] ? -factor : factor;
  assign t1ext  = NUM_W'(t1mag);
  assign t2ext  = NUM_W'({t2mag, {FRAC_W{1'b0}}});
  assign k_inc  = k + 1'b1;

  assign out_free  = !out_valid || out_ready;
  // output register takes a new item this cycle
  assign out_load  = out_free && (((state == B_IDLE) && cmd_valid) || (state == B_EMIT));
  assign cmd_ready = (state == B_IDLE) && out_free;
  assign div_start = (state == B_DSTART);

  cps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (mean),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (cmd_valid && out_free) begin
            out_valid  <= 1'b1;
            out_degree <= '0;
            out_value  <= ONE_Q32;
            out_sat    <= 1'b0;
            out_last   <= (cmd.top == '0);
            mmx        <= cmd.mmx;
            top        <= cmd.top;
            vp         <= ONE_Q32;
            vp2        <= '0;
            k          <= '0;
            ovf        <= 1'b0;
            if (cmd.top != '0) begin
              state <= B_FACT;
            end
          end
        end
        B_FACT: begin
          // degree one uses k = 0 with C0 = 1 and no second term
          fmag   <= fabs[FMAG_W-1:0];
          t1neg  <= factor[FACT_W-1] ^ vp[VAL_W-1];
          vmag   <= vp[VAL_W-1] ? -vp : vp;
          vp2mag <= vp2[VAL_W-1] ? -vp2 : vp2;
          t2neg  <= vp2[VAL_W-1];
          state  <= B_MUL_LO;
        end
        B_MUL_LO: begin
          acc_lo <= PROD_W'(fmag) * PROD_W'(vmag[HALF_W-1:0]);
          t2mag  <= T2_W'(vp2mag) * T2_W'(k);
          state  <= B_MUL_HI;
        end
        B_MUL_HI: begin
          acc_hi <= PROD_W'(fmag) * PROD_W'(vmag[VAL_W-1:HALF_W]);
          state  <= B_SUM;
        end
        B_SUM: begin
          t1mag <= T1_W'(acc_lo) + {acc_hi, {HALF_W{1'b0}}};
          state <= B_SIGN;
        end
        B_SIGN: begin
          s1    <= t1neg ? -t1ext : t1ext;
          s2    <= t2neg ? t2ext : -t2ext;
          state <= B_COMB;
        end
        B_COMB: begin
          num   <= s1 + s2;
          state <= B_DSTART;
        end
        B_DSTART: begin
          state <= B_DIV;
        end
        B_DIV: begin
          if (div_rsp.done) begin
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_degree <= k_inc;
            out_value  <= div_rsp.quot;
            out_sat    <= ovf | div_rsp.sat;
            out_last   <= (k_inc == top);
            ovf        <= ovf | div_rsp.sat;
            vp2        <= vp;
            vp         <= div_rsp.quot;
            k          <= k_inc;
            state      <= (k_inc == top) ? B_IDLE : B_FACT;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/charlier_polynomial_sequence.sv =====
// top level of the charlier polynomial sequence block
// depends on cps_pkg, cps_front, cps_queue, cps_back (and cps_div below it)
//
// usage:
//  - s_axis carries one item per request: an argument x (signed q16.16) and
//    a top degree n; m_axis returns n+1 items, C0(x) up to Cn(x) in rising
//    degree, each as a signed q32.32 value with its degree, tlast on degree n
//    and tuser set once any value of the request has saturated
//  - the poisson mean a (unsigned q16.16) sits in the apb register at byte
//    address 0; write it only while no request is in flight
//  - C0 passes through the front register, a queue entry and the output
//    register after the input handshake; every further degree runs the
//    split 33x32 multiply, the sign/combine steps and the bit-serial divider,
//    which finishes early when a quotient is zero or saturates
//  - the front stage and a two-entry queue take up to three more requests
//    while the engine is busy; one request is worked on at a time
//  - a stalled receiver holds the result in the output register; the engine
//    finishes the next quotient and then waits, nothing is dropped
//  - synchronous reset empties the queue, stops the engine, drops tvalid and
//    sets the mean back to 1.0
`default_nettype none

module charlier_polynomial_sequence import cps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // apb configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // x_value [31:0], top_degree [36:32], zeros
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // degree [4:0], poly_value [68:5], zeros
  output logic                   m_axis_tuser,   // saturated
  output logic                   m_axis_tlast    // last
);

  logic [MEAN_W-1:0]         poisson_mean;
  logic [APB_AW-REG_LSB-1:0] reg_index;
  logic                      reg_write;

  logic                      front_valid;
  logic                      front_ready;
  cmd_t                      front_cmd;
  logic                      queue_valid;
  logic                      queue_ready;
  cmd_t                      queue_cmd;

  logic [DEG_W-1:0]          out_degree;
  logic [VAL_W-1:0]          out_value;

  // register file: one register, word addressed
  assign reg_index = paddr[APB_AW-1:REG_LSB];
  assign reg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (reg_index == REG_POISSON_MEAN) ? poisson_mean : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      poisson_mean <= MEAN_RESET;
    end else if (reg_write && (reg_index == REG_POISSON_MEAN)) begin
      poisson_mean <= pwdata;
    end
  end

  // front: takes items and works out a - x
  cps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .x_value    (s_axis_tdata[X_W-1:0]),
    .top_degree (s_axis_tdata[X_W+DEG_W-1:X_W]),
    .mean       (poisson_mean),
    .cmd_valid  (front_valid),
    .cmd_ready  (front_ready),
    .cmd        (front_cmd)
  );

  // queue decouples the front from the recurrence engine
  cps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_cmd)
  );

  // back: recurrence, division and the output register
  cps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mean       (poisson_mean),
    .cmd_valid  (queue_valid),
    .cmd_ready  (queue_ready),
    .cmd        (queue_cmd),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_degree (out_degree),
    .out_value  (out_value),
    .out_sat    (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_value, out_degree};

endmodule

`default_nettype wire

// ===== hw/rtl/cps_checker.sv =====
// port-level checks for charlier_polynomial_sequence, bound to the top level
// depends on cps_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cps_checker import cps_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  logic             out_acc;
  logic [DEG_W-1:0] out_deg;
  logic [DEG_W-1:0] exp_deg;
  logic             sat_seen;

  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign out_deg = m_axis_tdata[DEG_W-1:0];

  // track the degree expected next and the sticky flag within a request
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_deg  <= '0;
      sat_seen <= 1'b0;
    end else if (out_acc) begin
      exp_deg  <= m_axis_tlast ? '0 : out_deg + 1'b1;
      sat_seen <= m_axis_tlast ? 1'b0 : m_axis_tuser;
    end
  end

  `CPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
  `CPS_ASSERT_IMPL(a_deg_order, out_acc, out_deg == exp_deg, "result degree out of order")
  `CPS_ASSERT_IMPL(a_sat_sticky, out_acc && sat_seen, m_axis_tuser, "saturation flag dropped")
  `CPS_ASSERT_IMPL(a_c0_one, out_acc && (out_deg == '0), (m_axis_tdata[VAL_W+DEG_W-1:DEG_W] == ONE_Q32) && !m_axis_tuser, "degree zero is not one")

endmodule

bind charlier_polynomial_sequence cps_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for charlier_polynomial_sequence
// drives argument/degree items and apb writes of the mean, predicts every term in 128-bit math
// depends on cps_pkg and the block's rtl only
`timescale 1ns / 1ps

module testbench;
  import cps_pkg::*;

  // cycles with items pending but no handshake
  localparam int WATCHDOG_LIMIT = 4000;
  // quiet cycles after the last term, well above one degree step
  localparam int DRAIN_CYCLES   = 200;
  // settle time before an apb write once the queues are empty
  localparam int SETTLE_CYCLES  = 20;

  // one request: argument x (q16.16) and top degree
  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [DEG_W-1:0] top;
  } charlier_arg_t;

  // one term of the sequence as it should leave the block
  typedef struct packed {
    logic [DEG_W-1:0] degree;
    logic [VAL_W-1:0] value;
    logic             clipped;
    logic             last;
  } charlier_term_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_CHOKE
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [APB_AW-1:0]      paddr   = '0;
  logic [APB_DW-1:0]      pwdata  = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // x_value [31:0], top_degree [36:32], zeros
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // degree [4:0], poly_value [68:5], zeros
  logic                   m_axis_tuser;         // saturated
  logic                   m_axis_tlast;         // last

  charlier_arg_t  pending_args[$];    // items not yet put on the bus
  charlier_term_t expected_terms[$];  // predicted terms, oldest first
  logic [MEAN_W-1:0] mean_q16 = MEAN_RESET;  // our copy of the poisson mean register
  int fail_count = 0;

  charlier_polynomial_sequence i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // truncating signed divide by the mean, clipped to the q32.32 range
  // a zero numerator gives zero even for a zero divisor
  function automatic logic [VAL_W-1:0] quotient_q32(input logic signed [127:0] num,
                                                    input logic [MEAN_W-1:0] den,
                                                    output bit clipped);
    logic [127:0] mag;
    logic [127:0] q;
    bit           neg;
    clipped = 1'b0;
    neg = num[127];
    mag = neg ? -num : num;
    if (mag == 128'd0) return '0;
    if (den == '0) begin
      clipped = 1'b1;
      return neg ? VAL_MIN : VAL_MAX;
    end
    q = mag / {96'd0, den};
    // negative side reaches one step further, to the most negative value
    if (q > (neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF)) begin
      clipped = 1'b1;
      return neg ? VAL_MIN : VAL_MAX;
    end
    return neg ? -q[VAL_W-1:0] : q[VAL_W-1:0];
  endfunction

  // all terms C0..Ctop of one request, three-term recurrence on the current mean
  function automatic void predict_charlier_terms(input logic [X_W-1:0] x,
                                                 input logic [DEG_W-1:0] top);
    logic signed [127:0] mmx;
    logic signed [127:0] factor;
    logic signed [127:0] prev;
    logic signed [127:0] prev2;
    logic signed [127:0] num;
    logic [VAL_W-1:0]    cur;
    bit                  clipped;
    bit                  sticky;
    charlier_term_t      term;
    sticky = 1'b0;
    mmx = $signed({96'd0, mean_q16}) - $signed({{96{x[X_W-1]}}, x});

    // C0 = 1.0, flag always clear here
    term = '{degree: '0, value: ONE_Q32, clipped: 1'b0, last: (top == 0)};
    expected_terms.push_back(term);
    if (top == 0) return;

    // C1 = (a - x) / a, numerator scaled by 2^32 so the quotient is q32.32
    num = mmx <<< 32;
    cur = quotient_q32(num, mean_q16, clipped);
    sticky |= clipped;
    term = '{degree: DEG_W'(1), value: cur, clipped: sticky, last: (top == 1)};
    expected_terms.push_back(term);
    prev2 = $signed({{64{ONE_Q32[VAL_W-1]}}, ONE_Q32});
    prev  = $signed({{64{cur[VAL_W-1]}}, cur});

    // later degrees go on with saturated values where they occurred
    for (int k = 1; k < top; k++) begin
      factor = mmx + (128'(k) <<< FRAC_W);
      num = factor * prev - prev2 * (128'(k) <<< FRAC_W);
      cur = quotient_q32(num, mean_q16, clipped);
      sticky |= clipped;
      term = '{degree: DEG_W'(k + 1), value: cur, clipped: sticky, last: (k + 1 == top)};
      expected_terms.push_back(term);
      prev2 = prev;
      prev  = $signed({{64{cur[VAL_W-1]}}, cur});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of items from pending_args with random gaps
  // ---------------------------------------------------------------------------

  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_args
    charlier_arg_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      // accepted item: its terms join the expectation queue now
      if (s_axis_tvalid && s_axis_tready)
        predict_charlier_terms(s_axis_tdata[X_W-1:0], s_axis_tdata[X_W +: DEG_W]);
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        // bus slot is free: present the next item unless in a gap
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_args.size() > 0) begin
          nxt = pending_args.pop_front();
          s_axis_tdata  <= {{IN_PAD_W{1'b0}}, nxt.top, nxt.x};
          s_axis_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            // a third of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall pattern and monitor
  // ---------------------------------------------------------------------------

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_tick = 0;

  always @(posedge clk) begin : stall_rx
    if (rx_mode_left <= 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(50, 400);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN: m_axis_tready <= 1'b1;
      RX_COIN: m_axis_tready <= ($urandom_range(0, 1) == 1);
      default: m_axis_tready <= ((rx_tick % 16) < 3);  // long stalls, short windows
    endcase
  end

  always @(posedge clk) begin : check_terms
    charlier_term_t got;
    charlier_term_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{degree:  m_axis_tdata[DEG_W-1:0],
              value:   m_axis_tdata[DEG_W +: VAL_W],
              clipped: m_axis_tuser,
              last:    m_axis_tlast};
      if (expected_terms.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected term: degree %0d value %h sat %b last %b",
                   got.degree, got.value, got.clipped, got.last);
        fail_count++;
      end else begin
        want = expected_terms.pop_front();
        if (got !== want) begin
          if (fail_count < 10)
            $display("term mismatch: expected deg %0d val %h sat %b last %b, got deg %0d val %h sat %b last %b",
                     want.degree, want.value, want.clipped, want.last,
                     got.degree, got.value, got.clipped, got.last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: work outstanding but nothing moving
  // ---------------------------------------------------------------------------

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_args.size() == 0 && expected_terms.size() == 0 && !s_axis_tvalid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("charlier_polynomial_sequence verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_item(input logic [X_W-1:0] x, input logic [DEG_W-1:0] top);
    pending_args.push_back('{x: x, top: top});
  endtask

  // random items; most use low degrees, since each degree costs a full divide
  task automatic queue_random(input int count);
    logic [X_W-1:0]   x;
    logic [DEG_W-1:0] top;
    int               pick;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       x = 32'h7FFF_FFFF;
        1:       x = 32'h8000_0000;
        2:       x = mean_q16;                                 // x = a, C1 is zero
        3, 4:    x = X_W'($signed($urandom_range(0, 40)) - 20) << FRAC_W;  // integer points
        default: x = $urandom;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 6)      top = $urandom_range(0, 6);
      else if (pick < 9) top = $urandom_range(7, 15);
      else               top = $urandom_range(16, 31);
      queue_item(x, top);
    end
  endtask

  // block is idle once nothing is pending, on the bus or expected
  task automatic wait_idle();
    while (pending_args.size() > 0 || s_axis_tvalid || expected_terms.size() > 0)
      @(posedge clk);
  endtask

  // write the mean while idle, through a setup and an access cycle
  task automatic reconfigure(input logic [MEAN_W-1:0] mean);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(REG_POISSON_MEAN) << REG_LSB;
    pwdata  <= mean;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mean_q16 = mean;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // mean 1.0 from reset: degree extremes, argument extremes, x = a
    queue_item(32'h0000_0000, 5'd0);
    queue_item(32'h0000_0000, 5'd1);
    queue_item(32'h0000_0000, 5'd31);
    queue_item(32'h7FFF_FFFF, 5'd31);
    queue_item(32'h8000_0000, 5'd31);   // growth saturates, later steps carry on
    queue_item(32'h0001_0000, 5'd5);    // zero numerator
    queue_item(32'h0002_0000, 5'd4);
    queue_item(32'hFFFF_0000, 5'd3);
    queue_item(32'h0000_0001, 5'd2);
    queue_item(32'hFFFF_FFFF, 5'd7);
    queue_random(50);

    // smallest mean: quotients blow up almost at once
    reconfigure(32'h0000_0001);
    queue_item(32'h8000_0000, 5'd31);
    queue_item(32'h7FFF_FFFF, 5'd3);
    queue_item(32'h0000_0001, 5'd2);    // x = a
    queue_random(50);

    // largest mean
    reconfigure(32'hFFFF_FFFF);
    queue_item(32'h8000_0000, 5'd31);
    queue_item(32'h7FFF_FFFF, 5'd31);
    queue_item(32'h0000_0000, 5'd1);
    queue_random(50);

    reconfigure(32'h0003_0000);
    queue_random(50);

    reconfigure($urandom_range(1, 32'hFFFF_FFFF));
    queue_random(50);

    reconfigure(32'h0000_8000);
    queue_random(30);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_terms.size() == 0) begin
      $display("charlier_polynomial_sequence verification clean");
    end else begin
      $display("charlier_polynomial_sequence verification failed");
    end
    $finish;
  end

endmodule
